@@ rtl/core/cssv_pkg.sv @@
// Shared constants, widths and pipeline types for the coherent-structure
// SGS viscosity block. No dependencies.
`timescale 1ns / 1ps

package cssv_pkg;

  // Fraction bits of the gradient components
  localparam int GRAD_FRAC_BITS = 16;

  // Port widths
  localparam int G_W  = 32;
  localparam int FW_W = 32;
  localparam int CP_W = 16;
  localparam int NU_W = 48;
  localparam int C_W  = 17;
  localparam int N_GRAD = 9;

  localparam logic [CP_W-1:0] CPRIME_RESET = 16'd2979;

  // Invariant widths
  localparam int S_W       = 68;  // 2 S:S and 2 W:W, exact
  localparam int NORM_BITS = 39;  // both invariants brought below 2^39
  localparam int K_W       = 5;   // shift 0..29
  localparam int E_W       = 40;
  localparam int MAG_W     = 39;
  localparam int FCS_FB    = 16;
  localparam int DREM_W    = 57;
  localparam int Q_W       = 17;  // |Fcs| in Q1.16, at most 65536
  localparam int DIV_STEPS = 17;
  localparam int SROOT_W   = 34;  // floor(sqrt(2 S:S))
  localparam int STRIAL_W  = 70;
  localparam int QX_W      = 33;  // |Fcs| << 16
  localparam int QTRIAL_W  = 35;
  localparam int ITER_STEPS = 34; // division then |Fcs| root; sqrt(2 S:S) alongside
  localparam int FO_W      = 18;
  localparam int CPP_W     = 33;
  localparam int CF_W      = 51;
  localparam int X_W       = 51;
  localparam int XL_W      = 32;
  localparam int DD_W      = 64;
  localparam int PROD_W    = 115;
  localparam int NU_SHIFT  = 32 + GRAD_FRAC_BITS;

  localparam logic [Q_W-1:0] FCS_ONE = 17'd65536;

  // Pipeline depth inside the datapath
  localparam int NSTAGE = 3 + (ITER_STEPS + 1) + 6;

  // Iteration-stage payload
  typedef struct packed {
    logic [S_W-1:0]     srem;
    logic [SROOT_W-1:0] sroot;
    logic [DREM_W-1:0]  drem;
    logic [E_W-1:0]     e;
    logic [Q_W-1:0]     q;
    logic               neg;
    logic               zero;
    logic [QX_W-1:0]    qrem;
    logic [Q_W-1:0]     qroot;
    logic [Q_W-1:0]     a;
    logic [DD_W-1:0]    dd;
  } iter_t;

endpackage

@@ rtl/core/coherent_structure_sgs_viscosity_top.sv @@
// Top level of the coherent-structure SGS eddy viscosity block: handshakes,
// c' register, output register and skid stage. Depends on cssv_pkg, cssv_core.
//
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid/in_ready, nine gradients, width | request in
//  out     | out_valid/out_ready, nu_sgs, coeff_c     | request out
//  cfg     | cfg_valid/cfg_ready, cfg_data (c')       | write in
//
// One request enters per cycle while in_ready is high; its result reaches
// the output register through the core. The 34-step shared iteration
// section (Fcs division then |Fcs| root, sqrt(2 S:S) running alongside)
// sets depth. Reset (rst_n low, synchronous) empties the pipeline and loads
// c' = 2979. A stall on out holds one result in the skid stage; then
// in_ready drops and the whole pipeline freezes until the skid drains.
`timescale 1ns / 1ps

module coherent_structure_sgs_viscosity_top import cssv_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [G_W-1:0]  in_g_xx,
  input  logic [G_W-1:0]  in_g_xy,
  input  logic [G_W-1:0]  in_g_xz,
  input  logic [G_W-1:0]  in_g_yx,
  input  logic [G_W-1:0]  in_g_yy,
  input  logic [G_W-1:0]  in_g_yz,
  input  logic [G_W-1:0]  in_g_zx,
  input  logic [G_W-1:0]  in_g_zy,
  input  logic [G_W-1:0]  in_g_zz,
  input  logic [FW_W-1:0] in_filter_width,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [NU_W-1:0] out_nu_sgs,
  output logic [C_W-1:0]  out_coeff_c,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [CP_W-1:0] cfg_data
);

  logic [CP_W-1:0] c_prime_r;
  logic            out_valid_r, skid_full_r;
  logic [NU_W-1:0] out_nu_r, skid_nu_r;
  logic [C_W-1:0]  out_c_r, skid_c_r;

  logic            core_v;
  logic [NU_W-1:0] core_nu;
  logic [C_W-1:0]  core_c;
  logic            adv;

  // pipeline moves whenever the skid stage has room
  assign adv       = !skid_full_r;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  cssv_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_v    (in_valid),
    .grad    ({in_g_zz, in_g_zy, in_g_zx, in_g_yz, in_g_yy, in_g_yx,
               in_g_xz, in_g_xy, in_g_xx}),
    .fw      (in_filter_width),
    .c_prime (c_prime_r),
    .out_v   (core_v),
    .nu      (core_nu),
    .coeff   (core_c)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_prime_r   <= CPRIME_RESET;
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        c_prime_r <= cfg_data;
      end
      if (skid_full_r) begin
        if (out_ready) begin
          skid_full_r <= 1'b0;
        end
      end else if (core_v) begin
        if (!(out_valid_r && !out_ready)) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_full_r <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (out_ready) begin
        out_nu_r <= skid_nu_r;
        out_c_r  <= skid_c_r;
      end
    end else if (core_v) begin
      if (!(out_valid_r && !out_ready)) begin
        out_nu_r <= core_nu;
        out_c_r  <= core_c;
      end else begin
        skid_nu_r <= core_nu;
        skid_c_r  <= core_c;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_nu_sgs  = out_nu_r;
  assign out_coeff_c = out_c_r;

  // skid holds data only behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid full with empty output register");

  // a blocked result coming out of the pipeline goes to the skid
  a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
    (core_v && !skid_full_r && out_valid_r && !out_ready) |=> skid_full_r)
    else $error("result lost at output stall");

  // draining the skid keeps the output full
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_full_r && out_ready) |=> (out_valid_r && !skid_full_r))
    else $error("skid drain dropped a result");

  // coefficient bound
  a_coeff_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_coeff_c <= 17'd131070))
    else $error("coefficient out of range");

  // zero coefficient means zero viscosity
  a_zero_nu: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_coeff_c == '0)) |-> (out_nu_sgs == '0))
    else $error("nonzero viscosity with zero coefficient");

endmodule

@@ rtl/core/cssv_core.sv @@
// Datapath pipeline: invariants, normalization, Fcs division, roots,
// coefficient and viscosity products. Depends on cssv_pkg.
`timescale 1ns / 1ps

module cssv_core import cssv_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_v,
  input  logic [N_GRAD-1:0][G_W-1:0] grad,
  input  logic [FW_W-1:0]            fw,
  input  logic [CP_W-1:0]            c_prime,
  output logic                       out_v,
  output logic [NU_W-1:0]            nu,
  output logic [C_W-1:0]             coeff
);

  // sqrt(2 S:S) step, bit j
  function automatic iter_t s_step(input iter_t c, input int j);
    logic [STRIAL_W-1:0] t;
    iter_t r;
    r = c;
    t = (STRIAL_W'(c.sroot) << (j + 1)) + (STRIAL_W'(1) << (2 * j));
    if ({2'b00, c.srem} >= t) begin
      r.srem = S_W'({2'b00, c.srem} - t);
      r.sroot[j] = 1'b1;
    end
    return r;
  endfunction

  // restoring division step, quotient bit j
  function automatic iter_t d_step(input iter_t c, input int j);
    logic [DREM_W-1:0] t;
    iter_t r;
    r = c;
    t = DREM_W'(c.e) << j;
    if (c.drem >= t) begin
      r.drem = c.drem - t;
      r.q[j] = 1'b1;
    end
    r.a     = r.zero ? '0 : r.q;
    r.qrem  = {r.a, 16'b0};
    r.qroot = '0;
    return r;
  endfunction

  // isqrt(|Fcs| << 16) step, bit j
  function automatic iter_t q_step(input iter_t c, input int j);
    logic [QTRIAL_W-1:0] t;
    iter_t r;
    r = c;
    t = (QTRIAL_W'(c.qroot) << (j + 1)) + (QTRIAL_W'(1) << (2 * j));
    if ({2'b00, c.qrem} >= t) begin
      r.qrem = QX_W'({2'b00, c.qrem} - t);
      r.qroot[j] = 1'b1;
    end
    return r;
  endfunction

  logic [NSTAGE-1:0] vld_r;

  // ---- stage 1: squares
  logic [63:0] pd_nxt [3], pd_r [3];
  logic [65:0] ps_nxt [3], ps_r [3];
  logic [65:0] pw_nxt [3], pw_r [3];
  logic [DD_W-1:0] dd1_nxt, dd1_r;

  always_comb begin
    logic [G_W-1:0] g;
    logic [G_W-1:0] dm;
    logic [G_W:0]   su, df, sm, wm;
    logic [G_W-1:0] u, v;
    for (int i = 0; i < 3; i++) begin
      g  = grad[i * 4];
      dm = g[G_W-1] ? (~g + 1'b1) : g;
      pd_nxt[i] = 64'(dm) * 64'(dm);
    end
    for (int i = 0; i < 3; i++) begin
      u = (i == 0) ? grad[1] : (i == 1) ? grad[2] : grad[5];
      v = (i == 0) ? grad[3] : (i == 1) ? grad[6] : grad[7];
      su = {u[G_W-1], u} + {v[G_W-1], v};
      df = {u[G_W-1], u} - {v[G_W-1], v};
      sm = su[G_W] ? (~su + 1'b1) : su;
      wm = df[G_W] ? (~df + 1'b1) : df;
      ps_nxt[i] = 66'(sm) * 66'(sm);
      pw_nxt[i] = 66'(wm) * 66'(wm);
    end
    dd1_nxt = DD_W'(fw) * DD_W'(fw);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd_r  <= pd_nxt;
      ps_r  <= ps_nxt;
      pw_r  <= pw_nxt;
      dd1_r <= dd1_nxt;
    end
  end

  // ---- stage 2: sums
  logic [S_W-1:0]  s2_nxt, s2_r, w2_nxt, w2_r;
  logic [DD_W-1:0] dd2_r;

  always_comb begin
    s2_nxt = ((S_W'(pd_r[0]) + S_W'(pd_r[1]) + S_W'(pd_r[2])) << 1)
           + S_W'(ps_r[0]) + S_W'(ps_r[1]) + S_W'(ps_r[2]);
    w2_nxt = S_W'(pw_r[0]) + S_W'(pw_r[1]) + S_W'(pw_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r  <= s2_nxt;
      w2_r  <= w2_nxt;
      dd2_r <= dd1_r;
    end
  end

  // ---- stage 3: common normalization shift
  logic [K_W-1:0]  k3_nxt, k3_r;
  logic [S_W-1:0]  s3_r, w3_r;
  logic [DD_W-1:0] dd3_r;

  always_comb begin
    logic [S_W-NORM_BITS-1:0] hi;
    hi = s2_r[S_W-1:NORM_BITS] | w2_r[S_W-1:NORM_BITS];
    k3_nxt = '0;
    for (int b = 0; b < S_W - NORM_BITS; b++) begin
      if (hi[b]) k3_nxt = K_W'(b + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k3_r  <= k3_nxt;
      s3_r  <= s2_r;
      w3_r  <= w2_r;
      dd3_r <= dd2_r;
    end
  end

  // ---- iteration stages
  iter_t iter_nxt [0:ITER_STEPS];
  iter_t iter_r   [0:ITER_STEPS];

  always_comb begin
    logic [S_W-1:0]   wsh, ssh;
    logic [MAG_W-1:0] ws, ss, mg;
    logic [E_W-1:0]   e;
    wsh = w3_r >> k3_r;
    ssh = s3_r >> k3_r;
    ws  = wsh[MAG_W-1:0];
    ss  = ssh[MAG_W-1:0];
    e   = E_W'(ws) + E_W'(ss);
    mg  = (ws < ss) ? (ss - ws) : (ws - ss);
    iter_nxt[0]       = '0;
    iter_nxt[0].srem  = s3_r;
    iter_nxt[0].drem  = DREM_W'({mg, 16'b0});
    iter_nxt[0].e     = e;
    iter_nxt[0].neg   = (ws < ss);
    iter_nxt[0].zero  = (e == '0);
    iter_nxt[0].dd    = dd3_r;
  end

  for (genvar t = 0; t < ITER_STEPS; t++) begin : g_it
    localparam int SJ = SROOT_W - 1 - t;
    if (t < DIV_STEPS) begin : g_div
      always_comb iter_nxt[t+1] = d_step(s_step(iter_r[t], SJ), DIV_STEPS - 1 - t);
    end else begin : g_qsq
      always_comb iter_nxt[t+1] = q_step(s_step(iter_r[t], SJ), Q_W - 1 - (t - DIV_STEPS));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      iter_r <= iter_nxt;
    end
  end

  // ---- stage P: |Fcs|^1.5 and FOmega
  logic [Q_W-1:0]     p_nxt, p_r;
  logic [FO_W-1:0]    fo_nxt, fo_r;
  logic [SROOT_W-1:0] rt_p_r;
  logic [DD_W-1:0]    dd_p_r;

  always_comb begin
    logic [2*Q_W-1:0] aq;
    aq     = (2*Q_W)'(iter_r[ITER_STEPS].a) * (2*Q_W)'(iter_r[ITER_STEPS].qroot);
    p_nxt  = aq[FCS_FB +: Q_W];
    fo_nxt = iter_r[ITER_STEPS].neg ? (FO_W'(FCS_ONE) + FO_W'(iter_r[ITER_STEPS].a))
                                    : (FO_W'(FCS_ONE) - FO_W'(iter_r[ITER_STEPS].a));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= p_nxt;
      fo_r   <= fo_nxt;
      rt_p_r <= iter_r[ITER_STEPS].sroot;
      dd_p_r <= iter_r[ITER_STEPS].dd;
    end
  end

  // ---- stage CP: c' * p
  logic [CPP_W-1:0]   cpp_nxt, cpp_r;
  logic [FO_W-1:0]    fo_c_r;
  logic [SROOT_W-1:0] rt_c_r;
  logic [DD_W-1:0]    dd_c_r;

  assign cpp_nxt = CPP_W'(c_prime) * CPP_W'(p_r);

  always_ff @(posedge clk) begin
    if (en) begin
      cpp_r  <= cpp_nxt;
      fo_c_r <= fo_r;
      rt_c_r <= rt_p_r;
      dd_c_r <= dd_p_r;
    end
  end

  // ---- stage C: coefficient
  logic [CF_W-1:0]    cf;
  logic [C_W-1:0]     c_nxt, c_r;
  logic [SROOT_W-1:0] rt_k_r;
  logic [DD_W-1:0]    dd_k_r;

  assign cf    = CF_W'(cpp_r) * CF_W'(fo_c_r);
  assign c_nxt = cf[32 +: C_W];

  always_ff @(posedge clk) begin
    if (en) begin
      c_r    <= c_nxt;
      rt_k_r <= rt_c_r;
      dd_k_r <= dd_c_r;
    end
  end

  // ---- stage X: C * sqrt(2 S:S)
  logic [X_W-1:0]  x_nxt, x_r;
  logic [C_W-1:0]  c_x_r;
  logic [DD_W-1:0] dd_x_r;

  assign x_nxt = X_W'(c_r) * X_W'(rt_k_r);

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      c_x_r  <= c_r;
      dd_x_r <= dd_k_r;
    end
  end

  // ---- stage PP: partial products of x * delta^2
  logic [63:0] pp0_r, pp1_r;
  logic [50:0] pp2_r, pp3_r;
  logic [C_W-1:0] c_pp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp0_r  <= 64'(x_r[XL_W-1:0]) * 64'(dd_x_r[31:0]);
      pp1_r  <= 64'(x_r[XL_W-1:0]) * 64'(dd_x_r[63:32]);
      pp2_r  <= 51'(x_r[X_W-1:XL_W]) * 51'(dd_x_r[31:0]);
      pp3_r  <= 51'(x_r[X_W-1:XL_W]) * 51'(dd_x_r[63:32]);
      c_pp_r <= c_x_r;
    end
  end

  // ---- stage NU: sum, scale, saturate
  logic [PROD_W-1:0] prod;
  logic [NU_W-1:0]   nu_nxt, nu_r;
  logic [C_W-1:0]    c_nu_r;

  always_comb begin
    prod = PROD_W'(pp0_r) + (PROD_W'(pp1_r) << 32) + (PROD_W'(pp2_r) << 32)
         + (PROD_W'(pp3_r) << 64);
    nu_nxt = (|prod[PROD_W-1:NU_SHIFT+NU_W]) ? '1 : prod[NU_SHIFT +: NU_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nu_r   <= nu_nxt;
      c_nu_r <= c_pp_r;
    end
  end

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTAGE-2:0], in_v};
    end
  end

  assign out_v = vld_r[NSTAGE-1];
  assign nu    = nu_r;
  assign coeff = c_nu_r;

endmodule
